@@ rtl/arc_pkg.sv @@
// Shared types, constants and list helpers for the ARC replacement block.
// Used by arc_front, arc_back, arc_cache_replacement and arc_chk.
// No dependencies.
package arc_pkg;

    localparam int SETS      = 64;
    localparam int WAYS      = 16;
    localparam int ADDR_BITS = 48;
    localparam int SET_W     = 6;
    localparam int WAY_W     = 5;
    localparam int DIRTY_W   = 16;
    localparam int IDX_W     = $clog2(WAYS);
    localparam int LEN_W     = $clog2(WAYS + 1);
    localparam int IN_DATA_W = 128;
    localparam int IN_USER_W = 2;
    localparam int OUT_DATA_W = 8;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_FILL   = 2'd0;
    localparam kind_t KIND_QUERY  = 2'd1;
    localparam kind_t KIND_UPDATE = 2'd2;

    typedef logic [ADDR_BITS-1:0]            addr_t;
    typedef logic [LEN_W-1:0]                len_t;
    typedef logic [WAYS-1:0][ADDR_BITS-1:0]  row_t;
    // Bit ADDR_BITS of each way is its valid flag.
    typedef logic [WAYS-1:0][ADDR_BITS:0]    tagrow_t;

    typedef struct packed {
        kind_t               kind;
        logic [SET_W-1:0]    set_index;
        addr_t               line_addr;
        addr_t               victim_line;
        logic [WAY_W-1:0]    way_index;
        logic                is_write;
        logic [DIRTY_W-1:0]  dirty_ways;
    } cmd_t;

    typedef struct packed {
        logic                tag_mismatch;
        logic                bypass;
        logic [WAY_W-1:0]    victim_way;
    } res_t;

    typedef struct packed {
        len_t t1;
        len_t t2;
        len_t b1;
        len_t b2;
    } lens_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } find_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_F_T1,
        ST_F_T2,
        ST_F_SRCH,
        ST_F_DIV,
        ST_F_APPLY,
        ST_Q_PICK,
        ST_Q_TAG,
        ST_U_MOVE,
        ST_WB
    } state_t;

    // First position among the live entries that holds the address.
    function automatic find_t list_find(row_t row, len_t n, addr_t a);
        find_t f;
        f.hit = 1'b0;
        f.idx = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (!f.hit && (LEN_W'(i) < n) && (row[i] == a)) begin
                f.hit = 1'b1;
                f.idx = IDX_W'(i);
            end
        end
        return f;
    endfunction

    // Close the gap at idx by shifting the older entries behind it one place toward the front.
    function automatic row_t list_remove(row_t row, logic [IDX_W-1:0] idx);
        row_t r;
        r = row;
        for (int i = 0; i < WAYS - 1; i++) begin
            if (IDX_W'(i) >= idx) begin
                r[i] = row[i+1];
            end
        end
        return r;
    endfunction

    // Insert at the front; the oldest entry falls off a full list.
    function automatic row_t list_push(row_t row, addr_t a);
        row_t r;
        r[0] = a;
        for (int i = 1; i < WAYS; i++) begin
            r[i] = row[i-1];
        end
        return r;
    endfunction

    function automatic len_t len_push(len_t n);
        return (n >= LEN_W'(WAYS)) ? LEN_W'(WAYS) : n + 1'b1;
    endfunction

endpackage

@@ rtl/arc_front.sv @@
// Front end: takes items from the input stream, drops those with no effect,
// queues the rest as commands. Depends on arc_pkg.
module arc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [arc_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic [arc_pkg::IN_USER_W-1:0] s_axis_tuser,
    output logic                        cmd_valid,
    input  logic                        cmd_ready,
    output arc_pkg::cmd_t               cmd
);
    import arc_pkg::*;

    cmd_t                 fifo_mem [FIFO_DEPTH];
    logic [FIFO_PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_PW:0]     count_reg, count_next;
    cmd_t                 in_cmd;
    logic                 was_hit;
    logic                 keep;
    logic                 push, pop;

    always_comb
    begin
        in_cmd.kind        = s_axis_tuser;
        in_cmd.set_index   = s_axis_tdata[5:0];
        in_cmd.line_addr   = s_axis_tdata[53:6];
        in_cmd.victim_line = s_axis_tdata[101:54];
        in_cmd.way_index   = s_axis_tdata[106:102];
        in_cmd.is_write    = s_axis_tdata[107];
        in_cmd.dirty_ways  = s_axis_tdata[124:109];
        was_hit            = s_axis_tdata[108];
    end

    // Drop unknown kinds and updates that are misses or name no way.
    always_comb
    begin
        case (in_cmd.kind)
            KIND_FILL, KIND_QUERY: keep = 1'b1;
            KIND_UPDATE:           keep = was_hit && (in_cmd.way_index < WAY_W'(WAYS));
            default:               keep = 1'b0;
        endcase
    end

    assign s_axis_tready = (count_reg != (FIFO_PW+1)'(FIFO_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready && keep;
    assign cmd_valid     = (count_reg != '0);
    assign pop           = cmd_valid && cmd_ready;
    assign cmd           = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ rtl/arc_back.sv @@
// Back end: per-set list memories, tag mirror and the sequencer that carries
// out fills, victim queries and hit promotions. Depends on arc_pkg.
module arc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  arc_pkg::cmd_t  cmd,
    output logic           res_valid,
    input  logic           res_ready,
    output arc_pkg::res_t  res
);
    import arc_pkg::*;

    // Row memories, one row per set.
    row_t    t1_mem  [SETS];
    row_t    t2_mem  [SETS];
    row_t    b1_mem  [SETS];
    row_t    b2_mem  [SETS];
    tagrow_t tag_mem [SETS];
    lens_t   len_mem [SETS];
    len_t    p_mem   [SETS];
    row_t    t1_rd_reg, t2_rd_reg, b1_rd_reg, b2_rd_reg;
    tagrow_t tag_rd_reg;
    lens_t   len_rd_reg;
    len_t    p_rd_reg;

    // A set whose valid bit is clear reads as empty lists, zero target, no tags.
    logic [SETS-1:0]    row_valid_reg;

    state_t  state_reg, state_next;
    cmd_t    cmd_reg;
    logic    rd_en, mem_we, res_load;

    row_t    t1_reg, t1_next, t2_reg, t2_next, b1_reg, b1_next, b2_reg, b2_next;
    tagrow_t tag_reg, tag_next;
    len_t    nt1_reg, nt1_next, nt2_reg, nt2_next, nb1_reg, nb1_next, nb2_reg, nb2_next;
    len_t    p_reg, p_next;
    logic    hb1_reg, hb1_next, hb2_reg, hb2_next;
    logic [IDX_W-1:0] ib1_reg, ib1_next, ib2_reg, ib2_next;
    len_t    quo_reg, quo_next, dvs_reg, dvs_next;
    logic [LEN_W:0] rem_reg, rem_next;
    logic [2:0] cnt_reg, cnt_next;
    addr_t   cand_reg, cand_next;
    logic    have_reg, have_next;
    res_t    fb_reg, fb_next;
    res_t    res_reg, res_next;
    logic    res_valid_reg;

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (cmd_valid) state_next = ST_LOAD;
            ST_LOAD:
            begin
                unique case (cmd_reg.kind)
                    KIND_FILL:  state_next = ST_F_T1;
                    KIND_QUERY: state_next = ST_Q_PICK;
                    default:    state_next = ST_U_MOVE;
                endcase
            end
            ST_F_T1:    state_next = ST_F_T2;
            ST_F_T2:    state_next = ST_F_SRCH;
            ST_F_SRCH:  state_next = (hb1_next || hb2_next) ? ST_F_DIV : ST_F_APPLY;
            ST_F_DIV:   if (cnt_reg == 3'd1) state_next = ST_F_APPLY;
            ST_F_APPLY: state_next = ST_WB;
            ST_Q_PICK:  state_next = ST_Q_TAG;
            ST_Q_TAG:   if (!res_valid_reg || res_ready) state_next = ST_WB;
            ST_U_MOVE:  state_next = ST_WB;
            ST_WB:      state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_ready = (state_reg == ST_IDLE);
        rd_en     = (state_reg == ST_IDLE) && cmd_valid;
        mem_we    = (state_reg == ST_WB);
        res_load  = (state_reg == ST_Q_TAG) && (!res_valid_reg || res_ready);
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        find_t fa, fb;
        lens_t lv;
        len_t  sz1, sz2, step, vt1, vb1, vb2, last;
        logic [LEN_W:0]   l1, l2, psum, remt;
        logic [LEN_W+1:0] l12;
        logic  pick_t1, in_b2, match, found;
        logic [WAY_W-1:0] mway;

        t1_next = t1_reg;   t2_next = t2_reg;   b1_next = b1_reg;   b2_next = b2_reg;
        tag_next = tag_reg;
        nt1_next = nt1_reg; nt2_next = nt2_reg; nb1_next = nb1_reg; nb2_next = nb2_reg;
        p_next = p_reg;
        hb1_next = hb1_reg; hb2_next = hb2_reg; ib1_next = ib1_reg; ib2_next = ib2_reg;
        quo_next = quo_reg; dvs_next = dvs_reg; rem_next = rem_reg; cnt_next = cnt_reg;
        cand_next = cand_reg; have_next = have_reg; fb_next = fb_reg; res_next = res_reg;
        fa = '0; fb = '0; lv = '0;
        sz1 = '0; sz2 = '0; step = '0; vt1 = '0; vb1 = '0; vb2 = '0; last = '0;
        l1 = '0; l2 = '0; psum = '0; remt = '0; l12 = '0;
        pick_t1 = 1'b0; in_b2 = 1'b0; match = 1'b0; found = 1'b0; mway = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                t1_next  = t1_rd_reg;
                t2_next  = t2_rd_reg;
                b1_next  = b1_rd_reg;
                b2_next  = b2_rd_reg;
                tag_next = row_valid_reg[cmd_reg.set_index] ? tag_rd_reg : '0;
                lv       = row_valid_reg[cmd_reg.set_index] ? len_rd_reg : '0;
                nt1_next = lv.t1;
                nt2_next = lv.t2;
                nb1_next = lv.b1;
                nb2_next = lv.b2;
                p_next   = row_valid_reg[cmd_reg.set_index] ? p_rd_reg : '0;
            end
            // Retire the evicted line to its ghost list.
            ST_F_T1:
            begin
                fa = list_find(t1_reg, nt1_reg, cmd_reg.victim_line);
                if ((cmd_reg.victim_line != '0) && fa.hit)
                begin
                    t1_next  = list_remove(t1_reg, fa.idx);
                    nt1_next = nt1_reg - 1'b1;
                    b1_next  = list_push(b1_reg, cmd_reg.victim_line);
                    nb1_next = len_push(nb1_reg);
                end
            end
            ST_F_T2:
            begin
                fa = list_find(t2_reg, nt2_reg, cmd_reg.victim_line);
                if ((cmd_reg.victim_line != '0) && fa.hit)
                begin
                    t2_next  = list_remove(t2_reg, fa.idx);
                    nt2_next = nt2_reg - 1'b1;
                    b2_next  = list_push(b2_reg, cmd_reg.victim_line);
                    nb2_next = len_push(nb2_reg);
                end
            end
            // Look up the line in both ghost lists and set up the ratio divide.
            ST_F_SRCH:
            begin
                sz1 = (nb1_reg == '0) ? LEN_W'(1) : nb1_reg;
                sz2 = (nb2_reg == '0) ? LEN_W'(1) : nb2_reg;
                fa  = list_find(b1_reg, nb1_reg, cmd_reg.line_addr);
                fb  = list_find(b2_reg, nb2_reg, cmd_reg.line_addr);
                hb1_next = fa.hit;
                ib1_next = fa.idx;
                hb2_next = fb.hit;
                ib2_next = fb.idx;
                rem_next = '0;
                cnt_next = 3'(LEN_W);
                quo_next = fa.hit ? sz2 : sz1;
                dvs_next = fa.hit ? sz1 : sz2;
            end
            // One restoring-division step per cycle.
            ST_F_DIV:
            begin
                remt = {rem_reg[LEN_W-1:0], quo_reg[LEN_W-1]};
                if (remt >= {1'b0, dvs_reg})
                begin
                    rem_next = remt - {1'b0, dvs_reg};
                    quo_next = {quo_reg[LEN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = remt;
                    quo_next = {quo_reg[LEN_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end
            ST_F_APPLY:
            begin
                step = (quo_reg == '0) ? LEN_W'(1) : quo_reg;
                if (hb1_reg)
                begin
                    psum     = {1'b0, p_reg} + {1'b0, step};
                    p_next   = (psum > (LEN_W+1)'(WAYS)) ? LEN_W'(WAYS) : psum[LEN_W-1:0];
                    b1_next  = list_remove(b1_reg, ib1_reg);
                    nb1_next = nb1_reg - 1'b1;
                    t2_next  = list_push(t2_reg, cmd_reg.line_addr);
                    nt2_next = len_push(nt2_reg);
                end
                else if (hb2_reg)
                begin
                    p_next   = (p_reg >= step) ? p_reg - step : '0;
                    b2_next  = list_remove(b2_reg, ib2_reg);
                    nb2_next = nb2_reg - 1'b1;
                    t2_next  = list_push(t2_reg, cmd_reg.line_addr);
                    nt2_next = len_push(nt2_reg);
                end
                else
                begin
                    vt1 = nt1_reg;
                    vb1 = nb1_reg;
                    vb2 = nb2_reg;
                    l1  = {1'b0, nt1_reg} + {1'b0, nb1_reg};
                    l2  = {1'b0, nt2_reg} + {1'b0, nb2_reg};
                    l12 = {1'b0, l1} + {1'b0, l2};
                    if (l1 >= (LEN_W+1)'(WAYS))
                    begin
                        if (nt1_reg < LEN_W'(WAYS))
                        begin
                            vb1 = (nb1_reg == '0) ? '0 : nb1_reg - 1'b1;
                        end
                        else
                        begin
                            vt1 = nt1_reg - 1'b1;
                        end
                    end
                    else if (l12 == (LEN_W+2)'(2 * WAYS))
                    begin
                        vb2 = (nb2_reg == '0) ? '0 : nb2_reg - 1'b1;
                    end
                    nb1_next = vb1;
                    nb2_next = vb2;
                    t1_next  = list_push(t1_reg, cmd_reg.line_addr);
                    nt1_next = len_push(vt1);
                end
                if (cmd_reg.way_index < WAY_W'(WAYS))
                begin
                    tag_next[cmd_reg.way_index[IDX_W-1:0]] = {1'b1, cmd_reg.line_addr};
                end
            end
            // Choose the candidate line, or the fallback answer when lists are empty.
            ST_Q_PICK:
            begin
                fb      = list_find(b2_reg, nb2_reg, cmd_reg.line_addr);
                in_b2   = fb.hit;
                pick_t1 = (nt1_reg != '0) &&
                          ((nt1_reg > p_reg) || (in_b2 && (nt1_reg == p_reg)));
                if (pick_t1)
                begin
                    last      = nt1_reg - 1'b1;
                    cand_next = t1_reg[last[IDX_W-1:0]];
                end
                else
                begin
                    last      = nt2_reg - 1'b1;
                    cand_next = t2_reg[last[IDX_W-1:0]];
                end
                have_next = pick_t1 || (nt2_reg != '0);
                fb_next.tag_mismatch = 1'b0;
                if (cmd_reg.is_write)
                begin
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (!found && !cmd_reg.dirty_ways[w])
                        begin
                            found = 1'b1;
                            mway  = WAY_W'(w);
                        end
                    end
                    fb_next.victim_way = mway;
                    fb_next.bypass     = 1'b0;
                end
                else
                begin
                    fb_next.victim_way = WAY_W'(WAYS);
                    fb_next.bypass     = 1'b1;
                end
            end
            // Map the candidate to a way; drop it from its list when no way holds it.
            ST_Q_TAG:
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    if (!match && tag_reg[w][ADDR_BITS] &&
                        (tag_reg[w][ADDR_BITS-1:0] == cand_reg))
                    begin
                        match = 1'b1;
                        mway  = WAY_W'(w);
                    end
                end
                fa = list_find(t1_reg, nt1_reg, cand_reg);
                fb = list_find(t2_reg, nt2_reg, cand_reg);
                if (res_load)
                begin
                    if (!have_reg)
                    begin
                        res_next = fb_reg;
                    end
                    else if (match)
                    begin
                        res_next.victim_way   = mway;
                        res_next.bypass       = 1'b0;
                        res_next.tag_mismatch = 1'b0;
                    end
                    else
                    begin
                        res_next.victim_way   = '0;
                        res_next.bypass       = 1'b0;
                        res_next.tag_mismatch = 1'b1;
                        if (fa.hit)
                        begin
                            t1_next  = list_remove(t1_reg, fa.idx);
                            nt1_next = nt1_reg - 1'b1;
                        end
                        else if (fb.hit)
                        begin
                            t2_next  = list_remove(t2_reg, fb.idx);
                            nt2_next = nt2_reg - 1'b1;
                        end
                    end
                end
            end
            // Promote a hit line to the front of T2.
            ST_U_MOVE:
            begin
                fa = list_find(t1_reg, nt1_reg, cmd_reg.line_addr);
                fb = list_find(t2_reg, nt2_reg, cmd_reg.line_addr);
                if (fa.hit)
                begin
                    t1_next  = list_remove(t1_reg, fa.idx);
                    nt1_next = nt1_reg - 1'b1;
                    t2_next  = list_push(t2_reg, cmd_reg.line_addr);
                    nt2_next = len_push(nt2_reg);
                end
                else if (fb.hit)
                begin
                    t2_next = list_push(list_remove(t2_reg, fb.idx), cmd_reg.line_addr);
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (mem_we)
            begin
                row_valid_reg[cmd_reg.set_index] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cmd_reg <= cmd;
        end
        t1_reg <= t1_next;  t2_reg <= t2_next;  b1_reg <= b1_next;  b2_reg <= b2_next;
        tag_reg <= tag_next;
        nt1_reg <= nt1_next; nt2_reg <= nt2_next; nb1_reg <= nb1_next; nb2_reg <= nb2_next;
        p_reg <= p_next;
        hb1_reg <= hb1_next; hb2_reg <= hb2_next; ib1_reg <= ib1_next; ib2_reg <= ib2_next;
        quo_reg <= quo_next; dvs_reg <= dvs_next; rem_reg <= rem_next; cnt_reg <= cnt_next;
        cand_reg <= cand_next; have_reg <= have_next; fb_reg <= fb_next; res_reg <= res_next;
    end

    // Row memories: one read port, one write port, registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            t1_mem[cmd_reg.set_index]  <= t1_reg;
            t2_mem[cmd_reg.set_index]  <= t2_reg;
            b1_mem[cmd_reg.set_index]  <= b1_reg;
            b2_mem[cmd_reg.set_index]  <= b2_reg;
            tag_mem[cmd_reg.set_index] <= tag_reg;
            len_mem[cmd_reg.set_index] <= '{t1: nt1_reg, t2: nt2_reg,
                                           b1: nb1_reg, b2: nb2_reg};
            p_mem[cmd_reg.set_index]   <= p_reg;
        end
        if (rd_en)
        begin
            t1_rd_reg  <= t1_mem[cmd.set_index];
            t2_rd_reg  <= t2_mem[cmd.set_index];
            b1_rd_reg  <= b1_mem[cmd.set_index];
            b2_rd_reg  <= b2_mem[cmd.set_index];
            tag_rd_reg <= tag_mem[cmd.set_index];
            len_rd_reg <= len_mem[cmd.set_index];
            p_rd_reg   <= p_mem[cmd.set_index];
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ rtl/arc_cache_replacement.sv @@
// Top level of the per-set ARC replacement policy block.
// Depends on arc_pkg, arc_front and arc_back.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready| tuser: kind; tdata: fields below
//  m_axis    | out       | m_axis_tvalid/m_axis_tready| tdata: victim_way, bypass, tag_mismatch
//
// One item at a time in the back end, driven by the sequencer over the
// one-row-per-cycle list memories: an update runs load, move and write-back;
// a query runs load, pick and tag, plus any wait for its result to leave, then
// write-back; a fill runs load, the two retire steps, search, the 5-step ratio
// divide when a ghost hit is found, apply and write-back. The front queue holds
// up to four items, so input keeps flowing while a result waits. Reset clears
// one valid bit per set, so an untouched set reads as empty lists, zero target
// and no tags; no clearing pass. Items that cannot change state are dropped in
// the front end and take no back-end time.
module arc_cache_replacement (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // set_index[5:0], line_addr[53:6], victim_line[101:54], way_index[106:102],
    // is_write[107], was_hit[108], dirty_ways[124:109], zero[127:125]
    input  logic [arc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind[1:0]
    input  logic [arc_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // victim_way[4:0], bypass[5], tag_mismatch[6], zero[7]
    output logic [arc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import arc_pkg::*;

    cmd_t cmd;
    logic cmd_valid, cmd_ready;
    res_t res;

    // Classify and queue incoming items.
    arc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    // Carry out each command against the set's lists and tag mirror.
    arc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // Pad the result to a whole byte.
    assign m_axis_tdata = {(OUT_DATA_W - $bits(res_t))'(0), res};

endmodule

@@ rtl/arc_chk.sv @@
// Port-level checks on the result stream of arc_cache_replacement.
// Depends on arc_pkg; bound to the top level below.
module arc_chk (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [arc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import arc_pkg::*;

    // Hold a stalled result.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[4:0] <= WAY_W'(WAYS))
        else $error("victim way out of range");

    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[4:0] == WAY_W'(WAYS) && !m_axis_tdata[6])
        else $error("bypass result with a real way or a mismatch");

    a_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[4:0] == '0 && !m_axis_tdata[5])
        else $error("tag mismatch result must name way 0 without bypass");

endmodule

bind arc_cache_replacement arc_chk u_arc_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
